// File: hdl/des_pkg.sv
// ----------------------------------------------------------------------------
// des_pkg: deadline event scheduler shared definitions
// Widths, request codes, sequencer states and sizing constants.
// ----------------------------------------------------------------------------
`default_nettype none

package des_pkg;

  // Number of deadline slots (1 to 16).
  localparam int unsigned NUM_EVENTS = 16;
  localparam int unsigned IDX_W      = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;

  // Fixed field widths.
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned EVT_W   = 4;
  localparam int unsigned DELTA_W = 32;
  localparam int unsigned MASK_W  = 16;
  localparam int unsigned TIME_W  = 64;

  localparam logic [DELTA_W-1:0] SAT32 = '1;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_SCHEDULE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CANCEL   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_ADVANCE  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPLY,
    ST_LOAD,
    ST_FIRE,
    ST_MIN,
    ST_FINAL
  } des_state_e;

endpackage : des_pkg

`default_nettype wire

// File: hdl/des_if.sv
// ----------------------------------------------------------------------------
// des_if: request and response channels
// Valid/ready channels carrying one request or one response beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface des_req_if;
  import des_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [REQ_W-1:0]     req_type;
  logic [EVT_W-1:0]     event_index;
  logic [DELTA_W-1:0]   delay_cycles;

  modport source (output valid, req_type, event_index, delay_cycles, input ready);
  modport sink   (input valid, req_type, event_index, delay_cycles, output ready);
endinterface : des_req_if

interface des_rsp_if;
  import des_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [MASK_W-1:0]    fired_mask;
  logic [DELTA_W-1:0]   cycles_to_next;

  modport source (output valid, fired_mask, cycles_to_next, input ready);
  modport sink   (input valid, fired_mask, cycles_to_next, output ready);
endinterface : des_rsp_if

`default_nettype wire

// File: hdl/des_addsub.sv
// ----------------------------------------------------------------------------
// des_addsub: shared 64-bit adder/subtractor
// The one arithmetic unit of the scheduler: a + b, or a - b with borrow.
// ----------------------------------------------------------------------------
`default_nettype none

module des_addsub (
  input  logic [des_pkg::TIME_W-1:0] a_i,
  input  logic [des_pkg::TIME_W-1:0] b_i,
  input  logic                       sub_i,
  output logic [des_pkg::TIME_W-1:0] sum_o,
  output logic                       borrow_o
);
  import des_pkg::*;

  logic [TIME_W:0] full;

  // Subtract as a plus inverted b plus one; borrow is a clear carry.
  assign full = {1'b0, a_i} + {1'b0, b_i ^ {TIME_W{sub_i}}} + {{TIME_W{1'b0}}, sub_i};

  assign sum_o    = full[TIME_W-1:0];
  assign borrow_o = sub_i & ~full[TIME_W];

endmodule : des_addsub

`default_nettype wire

// File: hdl/deadline_event_scheduler.sv
// ----------------------------------------------------------------------------
// deadline_event_scheduler: per-slot deadline event scheduler
// Cycle counter plus one deadline slot per event; schedule, cancel, advance.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one request beat: req_type (schedule, cancel, advance),
//   event_index and delay_cycles. rsp_o returns one beat per request with
//   fired_mask (slots fired by an advance) and cycles_to_next (cycles to the
//   nearest armed deadline, 0 if overdue, all ones if none armed or if the
//   gap does not fit in 32 bits).
//   One request is in flight at a time; req_i.ready is high only while the
//   sequencer idles. From acceptance a request runs through the apply and
//   load states, then the slot walk (one step per slot, an extra min step
//   for an armed slot that an advance does not fire), then the final state
//   that writes the response register. The single shared 64-bit
//   adder/subtractor and the deadline memory, visited one slot at a time,
//   set this pace. The next request is taken in the cycle after the
//   response is written.
//   The response sits in an output register, so the next request is taken
//   while a response waits; a stalled receiver holds the beat and only
//   blocks the sequencer when the next response is ready to be written.
//   Reset clears the counter, every armed bit and the response valid at
//   once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module deadline_event_scheduler (
  input  logic          clk_i,
  input  logic          rst_ni,
  des_req_if.sink       req_i,
  des_rsp_if.source     rsp_o
);
  import des_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_EVENTS - 1);

  des_state_e state_q, state_d;

  // Latched request
  logic [REQ_W-1:0]   req_q;
  logic [EVT_W-1:0]   slot_q;
  logic [DELTA_W-1:0] delta_q;

  // Scheduler state
  logic [TIME_W-1:0]     now_q, now_d;
  logic [NUM_EVENTS-1:0] armed_q, armed_d;

  // Walk state
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              any_q, any_d;
  logic [TIME_W-1:0] nearest_q, nearest_d;
  logic [MASK_W-1:0] fired_q, fired_d;

  // Response register
  logic               rsp_valid_q, rsp_valid_d;
  logic [MASK_W-1:0]  rsp_fired_q;
  logic [DELTA_W-1:0] rsp_cyc_q;
  logic [DELTA_W-1:0] cyc_next;
  logic               rsp_load;

  // Deadline memory
  logic [TIME_W-1:0] mem_q [NUM_EVENTS];
  logic [TIME_W-1:0] rdata_q;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;

  // Shared arithmetic unit
  logic [TIME_W-1:0] alu_a, alu_b, alu_sum;
  logic              alu_sub, alu_borrow;

  logic req_acc;
  logic slot_ok;
  logic is_adv;

  des_addsub u_addsub (
    .a_i      (alu_a),
    .b_i      (alu_b),
    .sub_i    (alu_sub),
    .sum_o    (alu_sum),
    .borrow_o (alu_borrow)
  );

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_acc     = req_i.valid & req_i.ready;
  assign slot_ok     = (32'(slot_q) < NUM_EVENTS);
  assign is_adv      = (req_q == REQ_ADVANCE);
  assign mem_waddr   = IDX_W'(slot_q);

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.fired_mask     = rsp_fired_q;
  assign rsp_o.cycles_to_next = rsp_cyc_q;

  // Sequencer: apply the request, walk the slots, then form the response.
  always_comb begin
    state_d     = state_q;
    now_d       = now_q;
    armed_d     = armed_q;
    idx_d       = idx_q;
    any_d       = any_q;
    nearest_d   = nearest_q;
    fired_d     = fired_q;
    rsp_valid_d = rsp_valid_q & ~rsp_o.ready;
    rsp_load    = 1'b0;
    mem_we      = 1'b0;
    cyc_next    = SAT32;
    alu_a       = now_q;
    alu_b       = {{(TIME_W-DELTA_W){1'b0}}, delta_q};
    alu_sub     = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (req_acc) begin
          any_d   = 1'b0;
          fired_d = '0;
          idx_d   = '0;
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        // now plus delta: new deadline for schedule, new time for advance
        case (req_q)
          REQ_SCHEDULE: begin
            if (slot_ok) begin
              mem_we                   = 1'b1;
              armed_d[IDX_W'(slot_q)]  = 1'b1;
            end
          end
          REQ_CANCEL: begin
            if (slot_ok) armed_d[IDX_W'(slot_q)] = 1'b0;
          end
          REQ_ADVANCE: now_d = alu_sum;
          default: ;
        endcase
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        // prime the read of slot zero after any write
        state_d = ST_FIRE;
      end
      ST_FIRE: begin
        if (!armed_q[idx_q]) begin
          state_d = (idx_q == LAST_IDX) ? ST_FINAL : ST_FIRE;
          idx_d   = (idx_q == LAST_IDX) ? idx_q : idx_q + 1'b1;
        end else if (is_adv) begin
          // deadline reached when now - deadline does not borrow
          alu_a   = now_q;
          alu_b   = rdata_q;
          alu_sub = 1'b1;
          if (!alu_borrow) begin
            armed_d[idx_q] = 1'b0;
            fired_d        = fired_q | (MASK_W'(1) << idx_q);
            state_d        = (idx_q == LAST_IDX) ? ST_FINAL : ST_FIRE;
            idx_d          = (idx_q == LAST_IDX) ? idx_q : idx_q + 1'b1;
          end else begin
            state_d = ST_MIN;
          end
        end else begin
          alu_a   = rdata_q;
          alu_b   = nearest_q;
          alu_sub = 1'b1;
          if (!any_q || alu_borrow) begin
            nearest_d = rdata_q;
            any_d     = 1'b1;
          end
          state_d = (idx_q == LAST_IDX) ? ST_FINAL : ST_FIRE;
          idx_d   = (idx_q == LAST_IDX) ? idx_q : idx_q + 1'b1;
        end
      end
      ST_MIN: begin
        alu_a   = rdata_q;
        alu_b   = nearest_q;
        alu_sub = 1'b1;
        if (!any_q || alu_borrow) begin
          nearest_d = rdata_q;
          any_d     = 1'b1;
        end
        state_d = (idx_q == LAST_IDX) ? ST_FINAL : ST_FIRE;
        idx_d   = (idx_q == LAST_IDX) ? idx_q : idx_q + 1'b1;
      end
      ST_FINAL: begin
        // gap = nearest - now; overdue when it borrows or is zero
        alu_a   = nearest_q;
        alu_b   = now_q;
        alu_sub = 1'b1;
        if (!any_q) begin
          cyc_next = SAT32;
        end else if (alu_borrow || (alu_sum == '0)) begin
          cyc_next = '0;
        end else if (|alu_sum[TIME_W-1:DELTA_W]) begin
          cyc_next = SAT32;
        end else begin
          cyc_next = alu_sum[DELTA_W-1:0];
        end
        // hold while the previous beat is still waiting
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_load    = 1'b1;
          rsp_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      now_q       <= '0;
      armed_q     <= '0;
      idx_q       <= '0;
      any_q       <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      now_q       <= now_d;
      armed_q     <= armed_d;
      idx_q       <= idx_d;
      any_q       <= any_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      req_q   <= req_i.req_type;
      slot_q  <= req_i.event_index;
      delta_q <= req_i.delay_cycles;
    end
    nearest_q <= nearest_d;
    fired_q   <= fired_d;
    if (rsp_load) begin
      rsp_fired_q <= fired_q;
      rsp_cyc_q   <= cyc_next;
    end
  end

  // Deadline memory: one write port, one registered read at the next index
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= alu_sum;
    rdata_q <= mem_q[idx_d];
  end

endmodule : deadline_event_scheduler

`default_nettype wire

// File: hdl/des_checker.sv
// ----------------------------------------------------------------------------
// des_checker: port-level checks for the deadline event scheduler
// Watches the request and response channels and the link between them.
// ----------------------------------------------------------------------------
`default_nettype none

module des_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        req_valid_i,
  input  logic                        req_ready_i,
  input  logic [des_pkg::REQ_W-1:0]   req_type_i,
  input  logic                        rsp_valid_i,
  input  logic                        rsp_ready_i,
  input  logic [des_pkg::MASK_W-1:0]  fired_mask_i,
  input  logic [des_pkg::DELTA_W-1:0] cycles_i
);
  import des_pkg::*;

  logic             req_acc;
  logic [REQ_W-1:0] last_req_q;

  assign req_acc = req_valid_i & req_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_req_q <= REQ_CANCEL;
    end else if (req_acc) begin
      last_req_q <= req_type_i;
    end
  end

  // Hold a stalled response beat.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(fired_mask_i) && $stable(cycles_i))
    else $error("response beat changed while stalled");

  // Busy after taking a request.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> !req_ready_i)
    else $error("request taken while busy");

  // Only an advance fires slots.
  a_fire_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) && (fired_mask_i != '0) |-> last_req_q == REQ_ADVANCE)
    else $error("slots fired by a request that is not an advance");

  // No response beat in the first cycles after a request.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> !$rose(rsp_valid_i) ##1 !$rose(rsp_valid_i))
    else $error("response appeared too early");

endmodule : des_checker

bind deadline_event_scheduler des_checker u_des_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .req_type_i   (req_i.req_type),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .fired_mask_i (rsp_o.fired_mask),
  .cycles_i     (rsp_o.cycles_to_next)
);

`default_nettype wire

// File: tb/tb_deadline_event_scheduler.sv
// ----------------------------------------------------------------------------
// tb_deadline_event_scheduler: request/response testbench for the scheduler
// Drives schedule, cancel, advance and unused request beats, predicts each
// response with an independent copy of counter and slot state, and checks
// every response beat in order under randomised idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_deadline_event_scheduler;
  import des_pkg::*;

  // The one request code the package leaves unnamed; it must change nothing.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  localparam int unsigned RAND_ITEMS   = 1680;
  localparam int unsigned HOLD_AT      = 200;  // response beats seen before the long hold
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 50;   // comfortably above the worst-case request time

  typedef struct packed {
    logic [MASK_W-1:0]  fired;
    logic [DELTA_W-1:0] gap;
  } sched_rsp_t;

  typedef struct packed {
    logic [REQ_W-1:0]   kind;
    logic [EVT_W-1:0]   slot;
    logic [DELTA_W-1:0] delta;
    logic               known;  // response typed in below rather than predicted
    sched_rsp_t         want;
  } sched_row_t;

  // Directed opening: walks the reset state, the unused code, cancel of an
  // idle slot, an instantly overdue schedule, the 32-bit saturation edge,
  // rescheduling, multi-slot firing and alternating bit patterns in delta.
  localparam int unsigned NUM_ROWS = 24;
  localparam sched_row_t DIRECTED [NUM_ROWS] = '{
    '{REQ_ADVANCE,  4'd0,  32'd0,          1'b1, '{16'h0000, SAT32}},
    '{REQ_UNUSED,   4'd15, 32'hFFFF_FFFF,  1'b1, '{16'h0000, SAT32}},
    '{REQ_CANCEL,   4'd5,  32'd0,          1'b1, '{16'h0000, SAT32}},
    '{REQ_SCHEDULE, 4'd0,  32'd0,          1'b1, '{16'h0000, 32'd0}},
    '{REQ_ADVANCE,  4'd6,  32'd0,          1'b1, '{16'h0001, SAT32}},
    '{REQ_SCHEDULE, 4'd15, 32'hFFFF_FFFF,  1'b1, '{16'h0000, SAT32}},
    '{REQ_SCHEDULE, 4'd3,  32'd100,        1'b1, '{16'h0000, 32'd100}},
    '{REQ_SCHEDULE, 4'd3,  32'd50,         1'b1, '{16'h0000, 32'd50}},
    '{REQ_CANCEL,   4'd3,  32'hFFFF_FFFF,  1'b1, '{16'h0000, SAT32}},
    '{REQ_ADVANCE,  4'd9,  32'hFFFF_FFFE,  1'b1, '{16'h0000, 32'd1}},
    '{REQ_ADVANCE,  4'd0,  32'd1,          1'b1, '{16'h8000, SAT32}},
    '{REQ_SCHEDULE, 4'd2,  32'd10,         1'b1, '{16'h0000, 32'd10}},
    '{REQ_SCHEDULE, 4'd9,  32'd20,         1'b1, '{16'h0000, 32'd10}},
    '{REQ_UNUSED,   4'd2,  32'd0,          1'b1, '{16'h0000, 32'd10}},
    '{REQ_ADVANCE,  4'd0,  32'd15,         1'b1, '{16'h0004, 32'd5}},
    '{REQ_ADVANCE,  4'd0,  32'd4,          1'b1, '{16'h0000, 32'd1}},
    '{REQ_ADVANCE,  4'd0,  32'd1,          1'b1, '{16'h0200, SAT32}},
    '{REQ_SCHEDULE, 4'd10, 32'd7,          1'b1, '{16'h0000, 32'd7}},
    '{REQ_SCHEDULE, 4'd5,  32'd7,          1'b1, '{16'h0000, 32'd7}},
    '{REQ_ADVANCE,  4'd0,  32'd100,        1'b1, '{16'h0420, SAT32}},
    '{REQ_SCHEDULE, 4'd12, 32'hAAAA_AAAA,  1'b0, '{16'h0000, 32'd0}},
    '{REQ_SCHEDULE, 4'd1,  32'h5555_5555,  1'b0, '{16'h0000, 32'd0}},
    '{REQ_CANCEL,   4'd1,  32'd0,          1'b0, '{16'h0000, 32'd0}},
    '{REQ_CANCEL,   4'd12, 32'h5555_5555,  1'b1, '{16'h0000, SAT32}}
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  des_req_if req_if ();
  des_rsp_if rsp_if ();

  deadline_event_scheduler i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor state: cycle counter, one deadline and one armed bit per slot.
  // --------------------------------------------------------------------------
  logic [TIME_W-1:0] sim_now;
  logic [TIME_W-1:0] sim_deadline [NUM_EVENTS];
  bit                sim_armed    [NUM_EVENTS];

  sched_rsp_t  due_results [$];  // responses still owed by the block, oldest first
  int unsigned mismatches = 0;
  int unsigned beats_out  = 0;   // response beats taken
  int unsigned snd_idle_pct;
  int unsigned rcv_idle_pct;
  bit          hold_done = 1'b0;

  // Cycles from now to the nearest armed deadline, clipped to 32 bits.
  // An armed slot counts whatever its deadline, so track presence separately.
  function automatic logic [DELTA_W-1:0] gap_to_nearest();
    bit                any_armed;
    logic [TIME_W-1:0] nearest;
    logic [TIME_W-1:0] diff;
    any_armed = 1'b0;
    nearest   = '0;
    for (int i = 0; i < NUM_EVENTS; i++) begin
      if (sim_armed[i] && (!any_armed || sim_deadline[i] < nearest)) begin
        nearest   = sim_deadline[i];
        any_armed = 1'b1;
      end
    end
    if (!any_armed) return SAT32;
    if (nearest <= sim_now) return '0;
    diff = nearest - sim_now;
    return (diff > {{(TIME_W-DELTA_W){1'b0}}, SAT32}) ? SAT32 : diff[DELTA_W-1:0];
  endfunction

  // Apply one request to the predictor and return the response it owes.
  function automatic sched_rsp_t apply_request(input logic [REQ_W-1:0]   kind,
                                               input logic [EVT_W-1:0]   slot,
                                               input logic [DELTA_W-1:0] delta);
    sched_rsp_t r;
    r.fired = '0;
    case (kind)
      REQ_SCHEDULE: begin
        // A later schedule of the same slot simply replaces its deadline.
        if (slot < NUM_EVENTS) begin
          sim_deadline[slot] = sim_now + delta;
          sim_armed[slot]    = 1'b1;
        end
      end
      REQ_CANCEL: begin
        if (slot < NUM_EVENTS) sim_armed[slot] = 1'b0;
      end
      REQ_ADVANCE: begin
        // Counter and deadlines wrap modulo 2^64; fire everything now reached.
        sim_now = sim_now + delta;
        for (int i = 0; i < NUM_EVENTS; i++) begin
          if (sim_armed[i] && sim_now >= sim_deadline[i]) begin
            sim_armed[i] = 1'b0;
            if (i < MASK_W) r.fired[i] = 1'b1;
          end
        end
      end
      default: ;  // unused code: state untouched
    endcase
    r.gap = gap_to_nearest();
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Request side. Called at a falling edge; returns at the falling edge after
  // the beat is taken, leaving valid high so back-to-back beats need no drop.
  // --------------------------------------------------------------------------
  task automatic issue_request(input logic [REQ_W-1:0]   kind,
                               input logic [EVT_W-1:0]   slot,
                               input logic [DELTA_W-1:0] delta,
                               input bit                 known,
                               input sched_rsp_t         typed);
    sched_rsp_t outcome;
    while ($urandom_range(99) < snd_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.req_type     <= kind;
    req_if.event_index  <= slot;
    req_if.delay_cycles <= delta;
    do @(posedge clk); while (!req_if.ready);
    // Predict on every beat so the model state stays in step, typed or not.
    outcome = apply_request(kind, slot, delta);
    due_results.push_back(known ? typed : outcome);
    @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Response side: sample at the rising edge, steer ready at the falling edge.
  // Once, hold ready low for a long stretch so the output register fills and
  // the request channel backs up while the sender keeps offering beats.
  // --------------------------------------------------------------------------
  initial begin
    sched_rsp_t want;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (rsp_if.valid && rsp_if.ready) begin
        beats_out++;
        if (due_results.size() == 0) begin
          mismatches++;
          $display("%0t: response beat with nothing outstanding, fired_mask %h cycles_to_next %h",
                   $time, rsp_if.fired_mask, rsp_if.cycles_to_next);
        end else begin
          want = due_results.pop_front();
          if (rsp_if.fired_mask !== want.fired) begin
            mismatches++;
            $display("%0t: fired_mask mismatch, expected %h, actual %h",
                     $time, want.fired, rsp_if.fired_mask);
          end
          if (rsp_if.cycles_to_next !== want.gap) begin
            mismatches++;
            $display("%0t: cycles_to_next mismatch, expected %h, actual %h",
                     $time, want.gap, rsp_if.cycles_to_next);
          end
        end
      end
      @(negedge clk);
      if (!hold_done && beats_out >= HOLD_AT) begin
        hold_done = 1'b1;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      rsp_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence: reset, directed table, random traffic, drain, verdict.
  // --------------------------------------------------------------------------
  initial begin
    logic [REQ_W-1:0]   kind;
    logic [EVT_W-1:0]   slot;
    logic [DELTA_W-1:0] delta;
    int unsigned        pick;
    int unsigned        shape;

    req_if.valid        <= 1'b0;
    req_if.req_type     <= REQ_SCHEDULE;
    req_if.event_index  <= '0;
    req_if.delay_cycles <= '0;
    rsp_if.ready        <= 1'b0;
    sim_now = '0;
    for (int i = 0; i < NUM_EVENTS; i++) begin
      sim_deadline[i] = '0;
      sim_armed[i]    = 1'b0;
    end
    snd_idle_pct = 19;
    rcv_idle_pct = 68;

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int n = 0; n < NUM_ROWS; n++) begin
      issue_request(DIRECTED[n].kind, DIRECTED[n].slot, DIRECTED[n].delta,
                    DIRECTED[n].known, DIRECTED[n].want);
    end

    // Mostly short delays so schedules and advances interleave and slots fire
    // often; a tail of huge and near-saturating delays and stray codes.
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == RAND_ITEMS / 3) begin
        snd_idle_pct = 68;
        rcv_idle_pct = 19;
      end else if (n == 2 * RAND_ITEMS / 3) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      pick = $urandom_range(99);
      if (pick < 40)      kind = REQ_SCHEDULE;
      else if (pick < 55) kind = REQ_CANCEL;
      else if (pick < 95) kind = REQ_ADVANCE;
      else                kind = REQ_UNUSED;
      slot  = EVT_W'($urandom_range(NUM_EVENTS - 1));
      shape = $urandom_range(99);
      if (shape < 70)      delta = $urandom_range(48);
      else if (shape < 85) delta = $urandom_range(5000);
      else if (shape < 95) delta = $urandom();
      else                 delta = SAT32 - $urandom_range(3);
      issue_request(kind, slot, delta, 1'b0, '0);
    end
    req_if.valid <= 1'b0;

    // Drain what is owed, then allow one more worst-case request time so any
    // stray beat shows up.
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule : tb_deadline_event_scheduler

// File: filelist.f
hdl/des_pkg.sv
hdl/des_if.sv
hdl/des_addsub.sv
hdl/deadline_event_scheduler.sv
hdl/des_checker.sv
tb/tb_deadline_event_scheduler.sv
